/* sv/pps_pkg.sv */
// Package of shared types, constants and codes for the preemptive priority scheduler.
`default_nettype none
package pps_pkg;

	// Field widths fixed by the item format.
	localparam int JOB_W      = 4;
	localparam int TIME_W     = 16;
	localparam int PRI_W      = 8;
	localparam int SUM_W      = 20;
	localparam int IN_DATA_W  = 48;
	localparam int IN_USER_W  = 1;
	localparam int OUT_DATA_W = 112;
	localparam int OUT_USER_W = 2;

	// Default table depth.
	localparam int MAX_JOBS_DEF = 16;

	// Saturation limits.
	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
	localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};

	// Input item kinds.
	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_UPDATE,
		S_EMIT
	} state_t;

	// One job table entry as held in the memory.
	typedef struct packed {
		logic [TIME_W-1:0] arrival;
		logic [TIME_W-1:0] remaining;
		logic [TIME_W-1:0] burst;
		logic [PRI_W-1:0]  pri;
	} job_entry_t;

	localparam int ENTRY_W = $bits(job_entry_t);

	// Control from the sequencer to the selector.
	typedef struct packed {
		logic clear;
		logic cmp_en;
	} sel_ctl_t;

endpackage
`default_nettype wire

/* sv/pps_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none
module pps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port with a registered read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

/* sv/pps_select.sv */
// Running selection of the highest-priority ready job during a table scan.
`default_nettype none
module pps_select #(
	parameter int MAX_JOBS = pps_pkg::MAX_JOBS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire pps_pkg::sel_ctl_t           ctl,
	input  wire logic [$clog2(MAX_JOBS)-1:0] cmp_idx,
	input  wire pps_pkg::job_entry_t         entry,
	input  wire logic                        eligible,
	input  wire logic [pps_pkg::TIME_W-1:0]  time_now,
	output logic                             found,
	output logic [$clog2(MAX_JOBS)-1:0]      best_idx,
	output pps_pkg::job_entry_t              best_entry
);
	import pps_pkg::*;

	logic found_q;
	logic wins;

	// A later slot wins only with a strictly larger priority, so ties go to the lower slot.
	assign wins = ctl.cmp_en && eligible && (entry.arrival <= time_now) &&
		(!found_q || (entry.pri > best_entry.pri));

	// Found flag is control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.clear) begin
			found_q <= 1'b0;
		end else if (wins) begin
			found_q <= 1'b1;
		end
	end

	// Best slot and its entry.
	always_ff @(posedge clk) begin
		if (wins) begin
			best_idx   <= cmp_idx;
			best_entry <= entry;
		end
	end

	assign found = found_q;

endmodule
`default_nettype wire

/* sv/preemptive_priority_scheduler.sv */
// Top level of the preemptive priority scheduler: sequencer, flags, totals and output register.
//
// Usage: items enter on the s_axis channel. tuser selects the kind: a load writes
// one job (slot, arrival time, burst, priority) into the job table, a tick serves
// the ready job with the largest priority (lower slot on a tie) for one time unit.
// A load produces no result. A tick produces exactly one result item on the m_axis
// channel, giving the slot served, completion data when the job finishes, the running
// totals and the time after the tick.
// On a tick the sequencer scans the table, one read per slot through the single read
// port of the job memory, and the registered read data feed the selector; an update
// state then writes back the remaining burst, and an emit state forms the result. A new
// item is accepted only once the sequencer is back in its idle state, while the previous
// result may still wait, so a tick must be through before the next item is taken.
// When the receiver stalls, the result holds in the output register and a following
// tick waits in its emit state until that register frees.
// Reset clears the valid and done flags, the time and the totals at once; the job
// memory itself is not cleared and needs no clearing pass.
`default_nettype none
module preemptive_priority_scheduler #(
	parameter int MAX_JOBS = pps_pkg::MAX_JOBS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	// Fields from bit 0: job_index[4], arrival_time[16], burst_length[16], job_priority[8].
	input  wire logic [pps_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// Fields from bit 0: op[1].
	input  wire logic [pps_pkg::IN_USER_W-1:0]  s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	// Fields from bit 0: running_job[4], completion_time[16], turnaround_time[16],
	// waiting_time[16], total_waiting[20], total_turnaround[20], time_now[16].
	output logic [pps_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	// Fields from bit 0: ran[1], finished[1].
	output logic [pps_pkg::OUT_USER_W-1:0]      m_axis_tuser
);
	import pps_pkg::*;

	localparam int IDX_W = $clog2(MAX_JOBS);
	localparam int CNT_W = $clog2(MAX_JOBS + 1);
	localparam logic [CNT_W-1:0] CNT_END = CNT_W'(MAX_JOBS);

	// Input fields.
	op_t               in_op;
	logic [JOB_W-1:0]  in_job;
	logic [TIME_W-1:0] in_arrival;
	logic [TIME_W-1:0] in_burst;
	logic [PRI_W-1:0]  in_pri;

	assign in_op      = op_t'(s_axis_tuser[0]);
	assign in_job     = s_axis_tdata[3:0];
	assign in_arrival = s_axis_tdata[19:4];
	assign in_burst   = s_axis_tdata[35:20];
	assign in_pri     = s_axis_tdata[43:36];

	// Sequencer and scan state.
	state_t            state_q, state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic              rd_pend_s1;
	logic [IDX_W-1:0]  rd_idx_s1;
	logic [MAX_JOBS-1:0] valid_q;
	logic [MAX_JOBS-1:0] done_q;
	logic [TIME_W-1:0] time_q;
	logic [SUM_W-1:0]  wait_sum_q;
	logic [SUM_W-1:0]  turn_sum_q;

	// Memory port signals.
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	job_entry_t        ram_wdata;
	logic              ram_re;
	logic [IDX_W-1:0]  ram_raddr;
	job_entry_t        ram_rdata;

	// Selector signals.
	sel_ctl_t          sel_ctl;
	logic              best_found;
	logic [IDX_W-1:0]  best_idx;
	job_entry_t        best_entry;

	// Handshake and control.
	logic              in_acc;
	logic              load_acc;
	logic              tick_acc;
	logic              slot_ok;
	logic              out_load;

	// Update datapath.
	logic [TIME_W-1:0] time_next;
	logic [TIME_W-1:0] rem_new;
	logic              fin_d;
	logic [TIME_W-1:0] turn_d;
	logic              ran_s2;
	logic              fin_s2;
	logic [TIME_W-1:0] turn_s2;
	logic [TIME_W-1:0] wait_d;
	logic [SUM_W:0]    wait_sum_raw;
	logic [SUM_W:0]    turn_sum_raw;
	logic [SUM_W-1:0]  wait_sum_d;
	logic [SUM_W-1:0]  turn_sum_d;

	// Output register.
	logic              out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic [OUT_USER_W-1:0] out_user_q;

	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign load_acc = in_acc && (in_op == OP_LOAD);
	assign tick_acc = in_acc && (in_op == OP_TICK);
	assign slot_ok  = int'(in_job) < MAX_JOBS;
	assign out_load = (state_q == S_EMIT) && (!out_valid_q || m_axis_tready);

	// Tick arithmetic: saturating time, remaining burst and turnaround.
	assign time_next = (time_q == TIME_MAX) ? TIME_MAX : time_q + TIME_W'(1);
	assign rem_new   = (best_entry.remaining != '0) ?
		best_entry.remaining - TIME_W'(1) : '0;
	assign fin_d     = best_found && (rem_new == '0);
	assign turn_d    = (time_next >= best_entry.arrival) ?
		time_next - best_entry.arrival : '0;

	// Waiting time and saturating totals for the result.
	assign wait_d       = (turn_s2 >= best_entry.burst) ? turn_s2 - best_entry.burst : '0;
	assign wait_sum_raw = {1'b0, wait_sum_q} + (SUM_W + 1)'(wait_d);
	assign turn_sum_raw = {1'b0, turn_sum_q} + (SUM_W + 1)'(turn_s2);
	assign wait_sum_d   = !fin_s2 ? wait_sum_q :
		(wait_sum_raw > (SUM_W + 1)'(SUM_MAX)) ? SUM_MAX : wait_sum_raw[SUM_W-1:0];
	assign turn_sum_d   = !fin_s2 ? turn_sum_q :
		(turn_sum_raw > (SUM_W + 1)'(SUM_MAX)) ? SUM_MAX : turn_sum_raw[SUM_W-1:0];

	// Next state and memory controls.
	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		ram_we        = 1'b0;
		ram_waddr     = IDX_W'(in_job);
		ram_wdata     = '{arrival: in_arrival, remaining: in_burst,
			burst: in_burst, pri: in_pri};
		ram_re        = 1'b0;
		ram_raddr     = cnt_q[IDX_W-1:0];
		sel_ctl       = '{clear: 1'b0, cmp_en: 1'b0};
		unique case (state_q)
			S_IDLE: begin
				s_axis_tready = 1'b1;
				ram_we        = load_acc && slot_ok;
				sel_ctl.clear = tick_acc;
				if (tick_acc) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				ram_re         = (cnt_q != CNT_END);
				sel_ctl.cmp_en = rd_pend_s1;
				if (cnt_q == CNT_END) begin
					state_d = S_UPDATE;
				end
			end
			S_UPDATE: begin
				ram_we    = best_found;
				ram_waddr = best_idx;
				ram_wdata = '{arrival: best_entry.arrival, remaining: rem_new,
					burst: best_entry.burst, pri: best_entry.pri};
				state_d   = S_EMIT;
			end
			S_EMIT: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
		endcase
	end

	// State register, scan counter and read pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			rd_pend_s1 <= 1'b0;
		end else begin
			state_q    <= state_d;
			rd_pend_s1 <= ram_re;
			if (tick_acc) begin
				cnt_q <= '0;
			end else if (ram_re) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= ram_raddr;
	end

	// Slot flags, time and totals.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			done_q     <= '0;
			time_q     <= '0;
			wait_sum_q <= '0;
			turn_sum_q <= '0;
		end else begin
			if (load_acc && slot_ok) begin
				valid_q[IDX_W'(in_job)] <= (in_burst != '0);
				done_q[IDX_W'(in_job)]  <= 1'b0;
			end
			if (state_q == S_UPDATE) begin
				time_q <= time_next;
				if (fin_d) begin
					done_q[best_idx] <= 1'b1;
				end
			end
			if (out_load) begin
				wait_sum_q <= wait_sum_d;
				turn_sum_q <= turn_sum_d;
			end
		end
	end

	// Results of the update cycle.
	always_ff @(posedge clk) begin
		if (state_q == S_UPDATE) begin
			ran_s2  <= best_found;
			fin_s2  <= fin_d;
			turn_s2 <= turn_d;
		end
	end

	// Output register and its valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_user_q <= {fin_s2, ran_s2};
			out_data_q <= {
				4'b0000,
				time_q,
				turn_sum_d,
				wait_sum_d,
				fin_s2 ? wait_d : '0,
				fin_s2 ? turn_s2 : '0,
				fin_s2 ? time_q : '0,
				ran_s2 ? JOB_W'(best_idx) : '0
			};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

	// Job table memory.
	pps_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_JOBS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Priority selection over the scan.
	pps_select #(
		.MAX_JOBS (MAX_JOBS)
	) u_select (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (sel_ctl),
		.cmp_idx    (rd_idx_s1),
		.entry      (ram_rdata),
		.eligible   (valid_q[rd_idx_s1] && !done_q[rd_idx_s1]),
		.time_now   (time_q),
		.found      (best_found),
		.best_idx   (best_idx),
		.best_entry (best_entry)
	);

	// The table is never written while a scan reads it.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> !ram_we)
		else $error("job table written during a scan");

	// A finished job is marked done by the time its result is formed.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && fin_s2) |-> done_q[best_idx])
		else $error("finished job not marked done");

	// Time never runs backward.
	assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (time_q >= $past(time_q)))
		else $error("time decreased");

	// A reported completion always comes with a served job.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (!fin_s2 || ran_s2))
		else $error("completion without a served job");

endmodule
`default_nettype wire
